// ===== sv/tdpc_pkg.sv =====
package tdpc_pkg;

  // Fixed field widths of the stream words.
  localparam int unsigned NUM_IN_W   = 32;
  localparam int unsigned TALLY_W    = 32;
  localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

  // Quotient bits retired by the remainder unit in each cycle.
  localparam int unsigned DIGIT_BITS = 4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the input word, restart the divisor at two
    logic div_start;  // begin a remainder pass for the current divisor
    logic next_div;   // step to the next divisor and its square
    logic emit;       // write the result into the output register
    logic prime;      // verdict that goes with emit
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic below_two;  // number is negative, zero or one
    logic sq_gt;      // divisor squared exceeds the number
    logic div_last;   // remainder pass is in its final cycle
    logic rem_zero;   // finished remainder is zero
    logic out_free;   // output register can take a word this cycle
  } status_t;

endpackage

// ===== sv/trial_division_prime_counter.sv =====
// Channel  Dir  Fields (low bit up)                           Handshake
// s_*      in   tdata: number_value[31:0]; tlast: set_end      s_tvalid/s_tready
// m_*      out  tdata: primes_so_far[31:0]; tuser: prime_flag;  m_tvalid/m_tready
//               tlast: final_count
//
// One word is tested at a time. Each trial divisor costs one pass through the
// shared remainder unit, so the time for a word grows with the divisors tried.
// Reset clears the tally, the controller and the output valid flag.
// A stalled output holds its word; the next input word is taken meanwhile.
module trial_division_prime_counter #(
  parameter int unsigned NUMBER_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // number_value[31:0]
  input  logic        s_tlast,   // set_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // primes_so_far[31:0]
  output logic        m_tuser,   // prime_flag
  output logic        m_tlast    // final_count
);

  tdpc_pkg::cmd_t    cmd;
  tdpc_pkg::status_t status;
  logic              idle;

  assign s_tready = idle;

  // Sequencer.
  tdpc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_fire (s_tvalid && idle),
    .status  (status),
    .cmd     (cmd),
    .idle    (idle)
  );

  // Divisor walk, remainder unit, tally and output register.
  tdpc_dp #(
    .NUMBER_BITS (NUMBER_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_number (s_tdata),
    .in_last   (s_tlast),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_count (m_tdata),
    .out_prime (m_tuser),
    .out_last  (m_tlast)
  );

endmodule

// ===== sv/tdpc_ctrl.sv =====
module tdpc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  tdpc_pkg::status_t status,
  output tdpc_pkg::cmd_t    cmd,
  output logic              idle
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TEST,
    S_DIV,
    S_REM,
    S_FINISH
  } state_t;

  state_t state;
  logic   prime;

  assign idle = (state == S_IDLE);

  // Command decode from the current state and datapath status.
  always_comb begin
    cmd           = '0;
    cmd.prime     = prime;
    cmd.load      = (state == S_IDLE) && in_fire;
    cmd.div_start = (state == S_TEST) && !status.below_two && !status.sq_gt;
    cmd.next_div  = (state == S_REM) && !status.rem_zero;
    cmd.emit      = (state == S_FINISH) && status.out_free;
  end

  // State register and the registered verdict.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      prime <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_fire) state <= S_TEST;
        end
        S_TEST: begin
          priority if (status.below_two) begin
            prime <= 1'b0;
            state <= S_FINISH;
          end else if (status.sq_gt) begin
            prime <= 1'b1;
            state <= S_FINISH;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (status.div_last) state <= S_REM;
        end
        S_REM: begin
          if (status.rem_zero) begin
            prime <= 1'b0;
            state <= S_FINISH;
          end else begin
            state <= S_TEST;
          end
        end
        S_FINISH: begin
          if (status.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/tdpc_dp.sv =====
module tdpc_dp #(
  parameter int unsigned NUMBER_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  tdpc_pkg::cmd_t                   cmd,
  output tdpc_pkg::status_t                status,
  input  logic [tdpc_pkg::NUM_IN_W-1:0]    in_number,
  input  logic                             in_last,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [tdpc_pkg::TALLY_W-1:0]     out_count,
  output logic                             out_prime,
  output logic                             out_last
);

  // Examined width, divisor width, padded shifter width and pass length.
  localparam int unsigned W     = (NUMBER_BITS > 32) ? 32 : ((NUMBER_BITS < 1) ? 1 : NUMBER_BITS);
  localparam int unsigned DW    = W / 2 + 1;
  localparam int unsigned SW    = 2 * DW;
  localparam int unsigned DB    = tdpc_pkg::DIGIT_BITS;
  localparam int unsigned PW    = ((W + DB - 1) / DB) * DB;
  localparam int unsigned CYC   = PW / DB;
  localparam int unsigned CNT_W = (CYC > 1) ? $clog2(CYC) : 1;

  logic [W-1:0]     num;
  logic             last;
  logic [DW-1:0]    divisor;
  logic [SW-1:0]    square;
  logic [PW-1:0]    shifter;
  logic [DW:0]      rem;
  logic [DW:0]      rem_next;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [tdpc_pkg::TALLY_W-1:0] tally;
  logic [tdpc_pkg::TALLY_W-1:0] tally_next;

  // Status toward the controller.
  assign status.below_two = num[W-1] || (num[W-1:1] == '0);
  assign status.sq_gt     = square > SW'(num);
  assign status.div_last  = busy && (cnt == '0);
  assign status.rem_zero  = (rem == '0);
  assign status.out_free  = !out_valid || out_ready;

  // Restoring remainder, several quotient bits per cycle, most significant first.
  always_comb begin
    logic [DW:0] r;
    r = busy ? rem : '0;
    for (int i = 0; i < DB; i++) begin
      r = {r[DW-1:0], shifter[PW-1-i]};
      if (r >= {1'b0, divisor}) r = r - {1'b0, divisor};
    end
    rem_next = r;
  end

  // Number capture, divisor walk and remainder pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      if (cmd.load) begin
        num     <= in_number[W-1:0];
        last    <= in_last;
        divisor <= DW'(2);
        square  <= SW'(4);
      end
      if (cmd.next_div) begin
        divisor <= divisor + DW'(1);
        square  <= square + SW'({divisor, 1'b0}) + SW'(1);
      end
      if (cmd.div_start) begin
        busy    <= 1'b1;
        cnt     <= CNT_W'(CYC - 1);
        shifter <= PW'(num);
        rem     <= '0;
      end else if (busy) begin
        rem     <= rem_next;
        shifter <= shifter << DB;
        cnt     <= cnt - CNT_W'(1);
        if (cnt == '0) busy <= 1'b0;
      end
    end
  end

  // Saturating tally including the item being emitted.
  assign tally_next = (cmd.prime && (tally != tdpc_pkg::TALLY_MAX)) ?
                      tally + tdpc_pkg::TALLY_W'(1) : tally;

  // Output register and tally update.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      tally     <= '0;
    end else begin
      if (cmd.emit) begin
        out_valid <= 1'b1;
        out_count <= tally_next;
        out_prime <= cmd.prime;
        out_last  <= last;
        tally     <= last ? '0 : tally_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/tdpc_chk.sv =====
module tdpc_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [31:0] s_tdata,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  // Reset leaves no word pending and the input open.
  a_reset_state: assert property (@(posedge clk) rst |=> !m_tvalid && s_tready)
    else $error("block not idle after reset");

  // Only one word is in work: input closes right after an accept.
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while a word is in work");

  // A prime result always carries a nonzero tally.
  a_prime_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata != 32'd0)
    else $error("prime reported with zero tally");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled result word changed");

endmodule

bind trial_division_prime_counter tdpc_chk u_tdpc_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
